// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

   localparam int COUNT_BITS = 16;
   localparam int TALLY_BITS = 40;

   localparam int ANC_W   = 17;
   localparam int PAIR_W  = 32;
   localparam int COV_W   = 19;
   localparam int MUT_W   = 17;
   localparam int CLS_W   = 3;
   localparam int BASE_W  = 3;
   localparam int OUT_TALLY_W = 40;
   localparam int NUM_BASES = 4;

   localparam int TOT_W  = COUNT_BITS + 1;
   localparam int ECOV_W = COUNT_BITS + 3;
   localparam int CMP_W  = (ECOV_W > COV_W) ? ECOV_W : COV_W;
   localparam int SQ_W   = 2 * TOT_W;
   localparam int FOURN_W = TOT_W + 2;

   localparam logic [BASE_W-1:0] BASE_A    = 3'd0;
   localparam logic [BASE_W-1:0] BASE_G    = 3'd1;
   localparam logic [BASE_W-1:0] BASE_C    = 3'd2;
   localparam logic [BASE_W-1:0] BASE_T    = 3'd3;
   localparam logic [BASE_W-1:0] BASE_NONE = 3'd4;

   typedef enum logic [1:0] {
      REG_ANC_COV_MIN = 2'd0,
      REG_ANC_COV_MAX = 2'd1,
      REG_END_COV_MIN = 2'd2,
      REG_END_COV_MAX = 2'd3
   } reg_index_type;

   typedef enum logic [CLS_W-1:0] {
      CLS_SKIPPED    = 3'd0,
      CLS_REJECTED   = 3'd1,
      CLS_UNMUTATED  = 3'd2,
      CLS_BALANCED   = 3'd3,
      CLS_UNBALANCED = 3'd4
   } class_type;

   typedef struct packed {
      logic [COV_W-1:0] anc_min;
      logic [COV_W-1:0] anc_max;
      logic [COV_W-1:0] end_min;
      logic [COV_W-1:0] end_max;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] fwd;
      logic [TOT_W-1:0]      tot;
      logic                  match;
   } lane_type;

   typedef struct packed {
      class_type          cls;
      logic               test;
      logic [COV_W-1:0]   end_cov;
      logic [MUT_W-1:0]   mut;
      logic [BASE_W-1:0]  mbase;
   } info_type;

endpackage

// ===== hw/rtl/psc_lane.sv =====
module psc_lane (
   input  logic [psc_pkg::ANC_W-1:0]  anc,
   input  logic [psc_pkg::PAIR_W-1:0] pair,
   input  logic [psc_pkg::COV_W-1:0]  anc_cov,
   output psc_pkg::lane_type          lane
);
   import psc_pkg::*;

   logic [2*COUNT_BITS-1:0] pair_x;
   logic [COUNT_BITS-1:0]   rev;

   assign pair_x = (2*COUNT_BITS)'(pair);
   assign rev    = pair_x[2*COUNT_BITS-1:COUNT_BITS];

   assign lane.fwd   = pair_x[COUNT_BITS-1:0];
   assign lane.tot   = TOT_W'(pair_x[COUNT_BITS-1:0]) + TOT_W'(rev);
   assign lane.match = (COV_W'(anc) == anc_cov);

endmodule

// ===== hw/rtl/psc_merge.sv =====
module psc_merge (
   input  logic                                  site_ok,
   input  psc_pkg::lane_type [psc_pkg::NUM_BASES-1:0] lanes,
   input  logic [psc_pkg::COV_W-1:0]             anc_cov,
   input  logic [psc_pkg::ECOV_W-1:0]            end_cov,
   input  psc_pkg::cfg_type                      cfg,
   output psc_pkg::info_type                     info,
   output logic [psc_pkg::COUNT_BITS-1:0]        f,
   output logic [psc_pkg::TOT_W-1:0]             n
);
   import psc_pkg::*;

   logic              ab_found;
   logic [1:0]        ab;
   logic [TOT_W-1:0]  mut;
   logic [BASE_W-1:0] mbase;
   logic              anc_ok;
   logic              end_ok;
   logic [CMP_W-1:0]  ecov_x;

   always_comb begin
      ab_found = 1'b0;
      ab       = 2'd0;
      for (int i = 0; i < NUM_BASES; i++) begin
         if (!ab_found && lanes[i].match) begin
            ab_found = 1'b1;
            ab       = 2'(i);
         end
      end
   end

   // later base wins a tie
   always_comb begin
      mut   = '0;
      mbase = BASE_NONE;
      if (ab_found) begin
         for (int i = 0; i < NUM_BASES; i++) begin
            if (2'(i) != ab && lanes[i].tot >= mut && lanes[i].tot != '0) begin
               mut   = lanes[i].tot;
               mbase = BASE_W'(i);
            end
         end
      end
   end

   assign ecov_x = CMP_W'(end_cov);
   assign anc_ok = ab_found && (anc_cov >= cfg.anc_min) && (anc_cov <= cfg.anc_max);
   assign end_ok = (ecov_x >= CMP_W'(cfg.end_min)) && (ecov_x <= CMP_W'(cfg.end_max));

   always_comb begin
      if (!site_ok) begin
         info.cls     = CLS_SKIPPED;
         info.test    = 1'b0;
         info.end_cov = '0;
         info.mut     = '0;
         info.mbase   = BASE_NONE;
      end else begin
         info.cls     = anc_ok ? CLS_UNMUTATED : CLS_REJECTED;
         info.test    = anc_ok && (mut != '0) && end_ok;
         info.end_cov = COV_W'(end_cov);
         info.mut     = MUT_W'(mut);
         info.mbase   = mbase;
      end
   end

   assign f = lanes[mbase[1:0]].fwd;
   assign n = lanes[mbase[1:0]].tot;

endmodule

// ===== hw/rtl/psc_balance.sv =====
module psc_balance (
   input  logic                           clock,
   input  logic                           en_c,
   input  logic                           en_d,
   input  logic [psc_pkg::COUNT_BITS-1:0] f,
   input  logic [psc_pkg::TOT_W-1:0]      n,
   output logic [psc_pkg::SQ_W-1:0]       sq,
   output logic [psc_pkg::FOURN_W-1:0]    four_n
);
   import psc_pkg::*;

   logic [TOT_W-1:0]   two_f;
   logic [TOT_W-1:0]   d_in;
   logic [TOT_W-1:0]   d_ff;
   logic [TOT_W-1:0]   n_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [FOURN_W-1:0] four_n_ff;

   assign two_f = {f, 1'b0};
   assign d_in  = (two_f >= n) ? (two_f - n) : (n - two_f);

   always_ff @(posedge clock) begin
      if (en_c) begin
         d_ff <= d_in;
         n_ff <= n;
      end
      if (en_d) begin
         sq_ff     <= SQ_W'(d_ff) * SQ_W'(d_ff);
         four_n_ff <= {n_ff, 2'b00};
      end
   end

   assign sq     = sq_ff;
   assign four_n = four_n_ff;

endmodule

// ===== hw/rtl/pileup_mutation_site_classifier.sv =====
// An accepted req_ beat passes through the a, b, c, d and e stage registers to rsp_valid.
// Throughput: one site per cycle while no stall backs up from rsp_ready; four base lanes, merge,
// two balance-test stages and the output register run as a five-stage pipeline.
// Up to five beats are held; req_ready drops only when every stage is full and rsp_ready is low, or in reset.
// Reset (synchronous): pipeline empty, tallies zero, windows set to 0 through 524280, ready low.
module pileup_mutation_site_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_site_ok,
   input  logic [psc_pkg::ANC_W-1:0]       req_anc_a_total,
   input  logic [psc_pkg::ANC_W-1:0]       req_anc_g_total,
   input  logic [psc_pkg::ANC_W-1:0]       req_anc_c_total,
   input  logic [psc_pkg::ANC_W-1:0]       req_anc_t_total,
   input  logic [psc_pkg::PAIR_W-1:0]      req_end_a_pair,
   input  logic [psc_pkg::PAIR_W-1:0]      req_end_g_pair,
   input  logic [psc_pkg::PAIR_W-1:0]      req_end_c_pair,
   input  logic [psc_pkg::PAIR_W-1:0]      req_end_t_pair,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [psc_pkg::CLS_W-1:0]       rsp_site_class,
   output logic [psc_pkg::COV_W-1:0]       rsp_end_coverage,
   output logic [psc_pkg::MUT_W-1:0]       rsp_alt_reads,
   output logic [psc_pkg::BASE_W-1:0]      rsp_mutated_base,
   output logic [psc_pkg::OUT_TALLY_W-1:0] rsp_selected_total,
   output logic [psc_pkg::OUT_TALLY_W-1:0] rsp_mutated_total,
   output logic [psc_pkg::OUT_TALLY_W-1:0] rsp_unbalanced_total,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [psc_pkg::COV_W-1:0]       csr_data
);
   import psc_pkg::*;

   localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

   cfg_type cfg_ff;

   logic [ANC_W-1:0]  anc   [NUM_BASES];
   logic [PAIR_W-1:0] pairs [NUM_BASES];
   lane_type [NUM_BASES-1:0] lanes;
   logic [COV_W-1:0]  anc_cov;
   logic [ECOV_W-1:0] end_cov;

   logic adv_a, adv_b, adv_c, adv_d, adv_e;
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;

   logic                     a_site_ok_ff;
   lane_type [NUM_BASES-1:0] a_lanes_ff;
   logic [COV_W-1:0]         a_anc_cov_ff;
   logic [ECOV_W-1:0]        a_end_cov_ff;

   info_type              b_info;
   logic [COUNT_BITS-1:0] b_f;
   logic [TOT_W-1:0]      b_n;
   info_type              b_info_ff;
   logic [COUNT_BITS-1:0] b_f_ff;
   logic [TOT_W-1:0]      b_n_ff;
   info_type              c_info_ff;
   info_type              d_info_ff;
   logic [SQ_W-1:0]       d_sq;
   logic [FOURN_W-1:0]    d_four_n;

   logic [TALLY_BITS-1:0] sel_ff, mut_ff, unb_ff;
   logic [TALLY_BITS-1:0] sel_in, mut_in, unb_in;
   class_type             cls_in;

   info_type e_info_ff;
   class_type e_cls_ff;

   assign anc[0] = req_anc_a_total;
   assign anc[1] = req_anc_g_total;
   assign anc[2] = req_anc_c_total;
   assign anc[3] = req_anc_t_total;
   assign pairs[0] = req_end_a_pair;
   assign pairs[1] = req_end_g_pair;
   assign pairs[2] = req_end_c_pair;
   assign pairs[3] = req_end_t_pair;

   assign anc_cov = COV_W'(anc[0]) + COV_W'(anc[1]) + COV_W'(anc[2]) + COV_W'(anc[3]);

   for (genvar g = 0; g < NUM_BASES; g++) begin : g_lane
      psc_lane u_lane (
         .anc     (anc[g]),
         .pair    (pairs[g]),
         .anc_cov (anc_cov),
         .lane    (lanes[g])
      );
   end

   assign end_cov = ECOV_W'(lanes[0].tot) + ECOV_W'(lanes[1].tot)
                  + ECOV_W'(lanes[2].tot) + ECOV_W'(lanes[3].tot);

   assign adv_e = !e_vld_ff || rsp_ready;
   assign adv_d = !d_vld_ff || adv_e;
   assign adv_c = !c_vld_ff || adv_d;
   assign adv_b = !b_vld_ff || adv_c;
   assign adv_a = !a_vld_ff || adv_b;
   assign req_ready = adv_a && !reset;
   assign csr_ready = !reset;

   psc_merge u_merge (
      .site_ok (a_site_ok_ff),
      .lanes   (a_lanes_ff),
      .anc_cov (a_anc_cov_ff),
      .end_cov (a_end_cov_ff),
      .cfg     (cfg_ff),
      .info    (b_info),
      .f       (b_f),
      .n       (b_n)
   );

   psc_balance u_balance (
      .clock  (clock),
      .en_c   (adv_c),
      .en_d   (adv_d),
      .f      (b_f_ff),
      .n      (b_n_ff),
      .sq     (d_sq),
      .four_n (d_four_n)
   );

   always_comb begin
      sel_in = sel_ff;
      mut_in = mut_ff;
      unb_in = unb_ff;
      cls_in = d_info_ff.cls;
      if (d_info_ff.cls == CLS_UNMUTATED) begin
         sel_in = (sel_ff == TALLY_MAX) ? sel_ff : sel_ff + 1'b1;
         if (d_info_ff.test) begin
            if (d_sq <= SQ_W'(d_four_n)) begin
               cls_in = CLS_BALANCED;
               mut_in = (mut_ff == TALLY_MAX) ? mut_ff : mut_ff + 1'b1;
            end else begin
               cls_in = CLS_UNBALANCED;
               unb_in = (unb_ff == TALLY_MAX) ? unb_ff : unb_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         sel_ff   <= '0;
         mut_ff   <= '0;
         unb_ff   <= '0;
         cfg_ff.anc_min <= '0;
         cfg_ff.anc_max <= COV_W'(524280);
         cfg_ff.end_min <= '0;
         cfg_ff.end_max <= COV_W'(524280);
      end else begin
         if (adv_a) a_vld_ff <= req_valid;
         if (adv_b) b_vld_ff <= a_vld_ff;
         if (adv_c) c_vld_ff <= b_vld_ff;
         if (adv_d) d_vld_ff <= c_vld_ff;
         if (adv_e) e_vld_ff <= d_vld_ff;
         if (adv_e && d_vld_ff) begin
            sel_ff <= sel_in;
            mut_ff <= mut_in;
            unb_ff <= unb_in;
         end
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_ANC_COV_MIN: cfg_ff.anc_min <= csr_data;
               REG_ANC_COV_MAX: cfg_ff.anc_max <= csr_data;
               REG_END_COV_MIN: cfg_ff.end_min <= csr_data;
               REG_END_COV_MAX: cfg_ff.end_max <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_site_ok_ff <= req_site_ok;
         a_lanes_ff   <= lanes;
         a_anc_cov_ff <= anc_cov;
         a_end_cov_ff <= end_cov;
      end
      if (adv_b) begin
         b_info_ff <= b_info;
         b_f_ff    <= b_f;
         b_n_ff    <= b_n;
      end
      if (adv_c) c_info_ff <= b_info_ff;
      if (adv_d) d_info_ff <= c_info_ff;
      if (adv_e) begin
         e_info_ff <= d_info_ff;
         e_cls_ff  <= cls_in;
      end
   end

   assign rsp_valid            = e_vld_ff;
   assign rsp_site_class       = e_cls_ff;
   assign rsp_end_coverage     = e_info_ff.end_cov;
   assign rsp_alt_reads        = e_info_ff.mut;
   assign rsp_mutated_base     = e_info_ff.mbase;
   assign rsp_selected_total   = OUT_TALLY_W'(sel_ff);
   assign rsp_mutated_total    = OUT_TALLY_W'(mut_ff);
   assign rsp_unbalanced_total = OUT_TALLY_W'(unb_ff);

endmodule

// ===== bench/pileup_mutation_site_classifier_tb.sv =====
module pileup_mutation_site_classifier_tb;
   import psc_pkg::*;

   localparam logic [COV_W-1:0] COV_FULL = 19'd524280;
   localparam int ANC_TOP = 131070;

   typedef struct packed {
      logic                                 site_ok;
      logic [NUM_BASES-1:0][ANC_W-1:0]      anc;
      logic [NUM_BASES-1:0][PAIR_W-1:0]     pair;
   } site_item_type;

   typedef struct packed {
      class_type                cls;
      logic [COV_W-1:0]         end_cov;
      logic [MUT_W-1:0]         mut;
      logic [BASE_W-1:0]        mbase;
      logic [OUT_TALLY_W-1:0]   sel;
      logic [OUT_TALLY_W-1:0]   bal;
      logic [OUT_TALLY_W-1:0]   unb;
   } site_result_type;

   class mutation_call_board;
      logic [COV_W-1:0]       anc_min, anc_max, end_min, end_max;
      logic [OUT_TALLY_W-1:0] sel_cnt, bal_cnt, unb_cnt;
      site_result_type        predicted_calls[$];
      int                     errors;

      function new();
         anc_min = '0;
         anc_max = COV_FULL;
         end_min = '0;
         end_max = COV_FULL;
         sel_cnt = '0;
         bal_cnt = '0;
         unb_cnt = '0;
         errors = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [COV_W-1:0] v);
         case (idx)
            REG_ANC_COV_MIN: anc_min = v;
            REG_ANC_COV_MAX: anc_max = v;
            REG_END_COV_MIN: end_min = v;
            REG_END_COV_MAX: end_max = v;
            default: ;
         endcase
      endfunction

      function logic [OUT_TALLY_W-1:0] bump(logic [OUT_TALLY_W-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function void note_site(site_item_type it);
         logic [NUM_BASES-1:0][63:0] fwd, tot;
         logic [63:0]                anc_cov, end_cov, best, f, n, d;
         int                         k, ab;
         site_result_type            r;
         anc_cov = 0;
         end_cov = 0;
         best = 0;
         ab = -1;
         r = '0;
         r.cls = CLS_SKIPPED;
         r.mbase = BASE_NONE;
         for (k = 0; k < NUM_BASES; k++) begin
            fwd[k] = 64'(it.pair[k][COUNT_BITS-1:0]);
            tot[k] = fwd[k] + 64'(it.pair[k][2*COUNT_BITS-1:COUNT_BITS]);
            anc_cov += 64'(it.anc[k]);
            end_cov += tot[k];
         end
         if (it.site_ok) begin
            // first base in A,G,C,T order holding all ancestor reads
            for (k = NUM_BASES - 1; k >= 0; k--)
               if (64'(it.anc[k]) == anc_cov) ab = k;
            if (ab >= 0) begin
               for (k = 0; k < NUM_BASES; k++) begin
                  if (k != ab && tot[k] != 0 && tot[k] >= best) begin
                     best = tot[k];
                     r.mbase = BASE_W'(k);
                  end
               end
            end
            if (ab >= 0 && anc_cov >= 64'(anc_min) && anc_cov <= 64'(anc_max)) begin
               sel_cnt = bump(sel_cnt);
               r.cls = CLS_UNMUTATED;
               if (best != 0 && end_cov >= 64'(end_min) && end_cov <= 64'(end_max)) begin
                  f = fwd[r.mbase[1:0]];
                  n = tot[r.mbase[1:0]];
                  d = (2 * f >= n) ? 2 * f - n : n - 2 * f;
                  if (d * d <= 4 * n) begin
                     bal_cnt = bump(bal_cnt);
                     r.cls = CLS_BALANCED;
                  end else begin
                     unb_cnt = bump(unb_cnt);
                     r.cls = CLS_UNBALANCED;
                  end
               end
            end else begin
               r.cls = CLS_REJECTED;
            end
            r.end_cov = end_cov[COV_W-1:0];
            r.mut = best[MUT_W-1:0];
         end
         r.sel = sel_cnt;
         r.bal = bal_cnt;
         r.unb = unb_cnt;
         predicted_calls.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(site_result_type got);
         site_result_type want;
         if (predicted_calls.size() == 0) begin
            $display("%0t: result beat with none expected, class %0d", $time, got.cls);
            errors++;
            return;
         end
         want = predicted_calls.pop_front();
         compare_field("site_class", 64'(want.cls), 64'(got.cls));
         compare_field("end_coverage", 64'(want.end_cov), 64'(got.end_cov));
         compare_field("alt_reads", 64'(want.mut), 64'(got.mut));
         compare_field("mutated_base", 64'(want.mbase), 64'(got.mbase));
         compare_field("selected_total", 64'(want.sel), 64'(got.sel));
         compare_field("mutated_total", 64'(want.bal), 64'(got.bal));
         compare_field("unbalanced_total", 64'(want.unb), 64'(got.unb));
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 1000000;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_site_ok = 1'b0;
   logic [ANC_W-1:0]         req_anc_a_total = '0;
   logic [ANC_W-1:0]         req_anc_g_total = '0;
   logic [ANC_W-1:0]         req_anc_c_total = '0;
   logic [ANC_W-1:0]         req_anc_t_total = '0;
   logic [PAIR_W-1:0]        req_end_a_pair = '0;
   logic [PAIR_W-1:0]        req_end_g_pair = '0;
   logic [PAIR_W-1:0]        req_end_c_pair = '0;
   logic [PAIR_W-1:0]        req_end_t_pair = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [CLS_W-1:0]         rsp_site_class;
   logic [COV_W-1:0]         rsp_end_coverage;
   logic [MUT_W-1:0]         rsp_alt_reads;
   logic [BASE_W-1:0]        rsp_mutated_base;
   logic [OUT_TALLY_W-1:0]   rsp_selected_total;
   logic [OUT_TALLY_W-1:0]   rsp_mutated_total;
   logic [OUT_TALLY_W-1:0]   rsp_unbalanced_total;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [1:0]               csr_index = '0;
   logic [COV_W-1:0]         csr_data = '0;

   mutation_call_board calls = new();
   logic               squeeze_go = 1'b0;
   logic               squeeze_done = 1'b0;
   int                 cycles = 0;

   pileup_mutation_site_classifier dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic logic [PAIR_W-1:0] strand_pair(int fwd, int rev);
      logic [31:0] fv, rv;
      fv = fwd;
      rv = rev;
      return {rv[COUNT_BITS-1:0], fv[COUNT_BITS-1:0]};
   endfunction

   function automatic site_item_type mk_site(bit ok, int a, int g, int c, int t,
         logic [PAIR_W-1:0] pa, logic [PAIR_W-1:0] pg,
         logic [PAIR_W-1:0] pc, logic [PAIR_W-1:0] pt);
      site_item_type it;
      it.site_ok = ok;
      it.anc[0] = ANC_W'(a);
      it.anc[1] = ANC_W'(g);
      it.anc[2] = ANC_W'(c);
      it.anc[3] = ANC_W'(t);
      it.pair[0] = pa;
      it.pair[1] = pg;
      it.pair[2] = pc;
      it.pair[3] = pt;
      return it;
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // mostly single-ancestor sites steered into the current windows
   function automatic site_item_type gen_site();
      site_item_type it;
      int amin, amax, emin, emax;
      int sel, ab, mb, k, scale, n, f, s, cov, rest, goal, pad;
      amin = int'(calls.anc_min);
      amax = int'(calls.anc_max);
      emin = int'(calls.end_min);
      emax = int'(calls.end_max);
      it = '0;
      it.site_ok = ($urandom_range(0, 99) >= 4);
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
         for (k = 0; k < NUM_BASES; k++) begin
            it.anc[k] = ANC_W'($urandom_range(0, ANC_TOP));
            it.pair[k] = $urandom();
         end
         return it;
      end
      if (sel < 12) begin
         ab = $urandom_range(0, 3);
         it.anc[ab] = ANC_W'($urandom_range(1, 60000));
         it.anc[(ab + $urandom_range(1, 3)) % 4] = ANC_W'($urandom_range(1, 60000));
         for (k = 0; k < NUM_BASES; k++)
            it.pair[k] = strand_pair($urandom_range(0, 30), $urandom_range(0, 30));
         return it;
      end
      ab = $urandom_range(0, 3);
      sel = $urandom_range(0, 9);
      if (sel < 7 && amin <= amax && amin <= ANC_TOP) begin
         cov = $urandom_range(amin, (amax > ANC_TOP) ? ANC_TOP : amax);
      end else begin
         case ($urandom_range(0, 4))
            0: cov = amin;
            1: cov = amax;
            2: cov = amin - 1;
            3: cov = amax + 1;
            default: cov = $urandom_range(0, ANC_TOP);
         endcase
         cov = clamp(cov, 0, ANC_TOP);
      end
      it.anc[ab] = ANC_W'(cov);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: scale = 20;
         5, 6, 7: scale = 400;
         8: scale = 6000;
         default: scale = 65535;
      endcase
      for (k = 0; k < NUM_BASES; k++)
         if (k != ab && $urandom_range(0, 2) == 0)
            it.pair[k] = strand_pair($urandom_range(0, scale / 4),
                                     $urandom_range(0, scale / 4));
      it.pair[ab] = strand_pair($urandom_range(0, scale), $urandom_range(0, scale));
      if ($urandom_range(0, 9) != 0) begin
         mb = (ab + $urandom_range(1, 3)) % 4;
         n = $urandom_range(1, scale);
         if ($urandom_range(0, 1)) begin
            s = 0;
            while (s * s < n) s++;
            f = clamp(n / 2 + int'($urandom_range(0, 2 * s + 2)) - (s + 1), 0, n);
         end else begin
            f = $urandom_range(0, n);
         end
         it.pair[mb] = strand_pair(f, n - f);
         if ($urandom_range(0, 3) == 0) begin
            k = (mb + $urandom_range(1, 3)) % 4;
            f = $urandom_range(0, n);
            if (k != ab) it.pair[k] = strand_pair(f, n - f);
         end
      end else begin
         for (k = 0; k < NUM_BASES; k++)
            if (k != ab) it.pair[k] = '0;
      end
      if (emin <= emax && $urandom_range(0, 3) != 0) begin
         rest = 0;
         for (k = 0; k < NUM_BASES; k++)
            if (k != ab) rest += int'(it.pair[k][15:0]) + int'(it.pair[k][31:16]);
         case ($urandom_range(0, 5))
            0: goal = emin;
            1: goal = emax;
            2: goal = emin - 1;
            3: goal = emax + 1;
            default: goal = $urandom_range(emin, emax);
         endcase
         pad = goal - rest;
         if (pad >= 0 && pad <= ANC_TOP) it.pair[ab] = strand_pair(pad - pad / 2, pad / 2);
      end
      return it;
   endfunction

   task automatic write_reg(reg_index_type idx, logic [COV_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      calls.set_reg(idx, v);
   endtask

   task automatic set_windows(int a_lo, int a_hi, int e_lo, int e_hi);
      write_reg(REG_ANC_COV_MIN, COV_W'(a_lo));
      write_reg(REG_ANC_COV_MAX, COV_W'(a_hi));
      write_reg(REG_END_COV_MIN, COV_W'(e_lo));
      write_reg(REG_END_COV_MAX, COV_W'(e_hi));
      csr_valid <= 1'b0;
   endtask

   // send a batch, then let the pipeline empty out
   task automatic send_batch(site_item_type batch[$]);
      int   i, gap;
      logic steady;
      steady = 1'b0;
      for (i = 0; i < batch.size(); i++) begin
         if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         gap = steady ? 0 : pick_pause();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_site_ok <= batch[i].site_ok;
         req_anc_a_total <= batch[i].anc[0];
         req_anc_g_total <= batch[i].anc[1];
         req_anc_c_total <= batch[i].anc[2];
         req_anc_t_total <= batch[i].anc[3];
         req_end_a_pair <= batch[i].pair[0];
         req_end_g_pair <= batch[i].pair[1];
         req_end_c_pair <= batch[i].pair[2];
         req_end_t_pair <= batch[i].pair[3];
         @(negedge clock);
         while (!req_ready) @(negedge clock);
         @(posedge clock);
         calls.note_site(batch[i]);
      end
      req_valid <= 1'b0;
      while (calls.predicted_calls.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int              stall_left, tick;
      logic            steady;
      site_result_type got;
      stall_left = 0;
      tick = 0;
      steady = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (squeeze_go && !squeeze_done) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            squeeze_done = 1'b1;
         end
         if (tick % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         tick++;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady) stall_left = pick_pause();
         end
         @(negedge clock);
         if (rsp_valid && rsp_ready) begin
            got.cls = class_type'(rsp_site_class);
            got.end_cov = rsp_end_coverage;
            got.mut = rsp_alt_reads;
            got.mbase = rsp_mutated_base;
            got.sel = rsp_selected_total;
            got.bal = rsp_mutated_total;
            got.unb = rsp_unbalanced_total;
            calls.check_result(got);
         end
      end
   end

   initial begin
      site_item_type batch[$];
      int            ph, i, a_lo, e_lo;
      int            phase_items[7] = '{420, 420, 60, 60, 60, 420, 420};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // open windows: skipped site, zero coverage, ties, balance boundaries
      batch = {};
      batch.push_back(mk_site(0, 7, 8, 9, ANC_TOP, 32'hFFFFFFFF, 32'h12345678, 0,
                              strand_pair(3, 4)));
      batch.push_back(mk_site(1, 0, 0, 0, 0, 0, 0, 0, 0));
      batch.push_back(mk_site(1, 5, 3, 0, 0, strand_pair(1, 1), strand_pair(2, 0), 0, 0));
      batch.push_back(mk_site(1, 0, ANC_TOP, 0, 0, strand_pair(7, 3), strand_pair(50, 50),
                              strand_pair(4, 6), strand_pair(2, 1)));
      batch.push_back(mk_site(1, 0, 0, 0, ANC_TOP, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 32'hFFFFFFFF));
      batch.push_back(mk_site(1, 0, 0, 10, 0, 0, 0, strand_pair(20, 20),
                              strand_pair(100, 0)));
      batch.push_back(mk_site(1, ANC_TOP, 0, 0, 0, strand_pair(1000, 900),
                              strand_pair(0, 4), 0, 0));
      batch.push_back(mk_site(1, ANC_TOP, 0, 0, 0, strand_pair(5, 5), 0,
                              strand_pair(0, 5), 0));
      batch.push_back(mk_site(1, 0, 0, 0, 1, 0, strand_pair(12, 4), 0, strand_pair(9, 9)));
      batch.push_back(mk_site(1, 0, 0, 0, 1, 0, strand_pair(13, 3), 0, 0));
      batch.push_back(mk_site(1, 0, 0, 64, 0, 0, 0, strand_pair(30, 30), 0));
      batch.push_back(mk_site(1, ANC_TOP, ANC_TOP, ANC_TOP, ANC_TOP, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
      batch.push_back(mk_site(1, 0, 1, 0, 0, 0, 0, 0, strand_pair(65535, 0)));
      batch.push_back(mk_site(1, 1, 0, 0, 0, 0, strand_pair(0, 65535), 0, 0));
      send_batch(batch);

      // window edges
      set_windows(100, 200, 50, 60);
      batch = {};
      batch.push_back(mk_site(1, 99, 0, 0, 0, strand_pair(20, 20), strand_pair(5, 5), 0, 0));
      batch.push_back(mk_site(1, 100, 0, 0, 0, strand_pair(20, 20), strand_pair(5, 5), 0, 0));
      batch.push_back(mk_site(1, 200, 0, 0, 0, strand_pair(25, 25), strand_pair(5, 5), 0, 0));
      batch.push_back(mk_site(1, 201, 0, 0, 0, strand_pair(25, 25), strand_pair(5, 5), 0, 0));
      batch.push_back(mk_site(1, 150, 0, 0, 0, strand_pair(20, 19), strand_pair(5, 5), 0, 0));
      batch.push_back(mk_site(1, 150, 0, 0, 0, strand_pair(26, 25), strand_pair(5, 5), 0, 0));
      send_batch(batch);

      // inverted windows
      set_windows(10, 5, 0, int'(COV_FULL));
      batch = {};
      batch.push_back(mk_site(1, 0, 7, 0, 0, strand_pair(3, 3), 0, 0, 0));
      send_batch(batch);
      set_windows(0, int'(COV_FULL), 60, 50);
      batch = {};
      batch.push_back(mk_site(1, 0, 0, 55, 0, strand_pair(20, 20), 0, strand_pair(5, 5), 0));
      send_batch(batch);

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_windows(0, int'(COV_FULL), 0, int'(COV_FULL));
            1: set_windows(20, 5000, 10, 3000);
            2: set_windows(0, 0, int'(COV_FULL), int'(COV_FULL));
            3: set_windows(ANC_TOP, int'(COV_FULL), 0, 0);
            4: set_windows(300, 200, 500, 400);
            5: begin
               a_lo = $urandom_range(0, 2000);
               e_lo = $urandom_range(0, 200);
               set_windows(a_lo, a_lo + int'($urandom_range(0, 60000)),
                           e_lo, e_lo + int'($urandom_range(0, 3000)));
            end
            default: set_windows(1, ANC_TOP, 1, int'(COV_FULL));
         endcase
         batch = {};
         for (i = 0; i < phase_items[ph]; i++) batch.push_back(gen_site());
         // long receiver hold-off while the sender keeps going
         if (ph == 1) squeeze_go = 1'b1;
         send_batch(batch);
      end

      repeat (20) @(posedge clock);
      if (calls.errors == 0 && calls.predicted_calls.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/psc_pkg.sv
hw/rtl/psc_lane.sv
hw/rtl/psc_merge.sv
hw/rtl/psc_balance.sv
hw/rtl/pileup_mutation_site_classifier.sv
bench/pileup_mutation_site_classifier_tb.sv
